[rtl/dctg_pkg.sv]
// Shared types, constants and per-size tables for the DCT coefficient generator.
package dctg_pkg;

	localparam int MAX_SIZE      = 64;
	localparam int CORDIC_STAGES = 18;
	localparam int SIZE_W        = 7;
	localparam int IDX_W         = 6;
	localparam int COEF_W        = 18;
	localparam int PROD_W        = 13;
	localparam int RECIP_SH      = 26;
	localparam int RECIP_W       = 27;
	localparam int ANG_W         = 34;
	localparam int SCALE_W       = 31;
	localparam int ROW0_W        = 17;
	localparam int STG_W         = 5;
	localparam int APB_AW        = 3;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic REG_MATRIX_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

	typedef logic [31:0] atan_tbl_t [0:31];
	localparam atan_tbl_t ATAN_TBL = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	typedef logic [SCALE_W-1:0] scale_tbl_t [0:MAX_SIZE];
	typedef logic [ROW0_W-1:0]  row0_tbl_t  [0:MAX_SIZE];
	typedef logic [RECIP_W-1:0] recip_tbl_t [0:MAX_SIZE];
	typedef logic [IDX_W-1:0]   hrem_tbl_t  [0:MAX_SIZE];

	typedef struct packed {
		logic                valid;
		logic                err;
		logic                row0;
		logic [1:0]          quad;
		logic [SCALE_W-1:0]  scale;
		logic [ROW0_W-1:0]   row0_val;
	} meta_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// shift-subtract quotient, used only while building constant tables
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], a[i]};
			if (rem >= {1'b0, b}) begin
				rem = rem - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// CORDIC gain inverse in Q30, built stage by stage
	function automatic logic [63:0] build_gain();
		logic [63:0] k;
		logic [63:0] d;
		k = 64'd1 << 30;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (i <= 30) begin
				d = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
				k = udiv64(k << 30, d);
			end
		end
		return k;
	endfunction

	localparam logic [63:0] GAIN_Q30 = build_gain();

	function automatic scale_tbl_t build_scale();
		scale_tbl_t t;
		t[0] = '0;
		for (int n = 1; n <= MAX_SIZE; n++)
			t[n] = SCALE_W'(isqrt64(udiv64(64'd1 << 61, 64'(n))));
		return t;
	endfunction

	function automatic row0_tbl_t build_row0();
		row0_tbl_t t;
		t[0] = '0;
		for (int n = 1; n <= MAX_SIZE; n++)
			t[n] = ROW0_W'((isqrt64(udiv64(64'd1 << 34, 64'(n))) + 64'd1) >> 1);
		return t;
	endfunction

	function automatic recip_tbl_t build_recip();
		recip_tbl_t t;
		t[0] = '0;
		for (int n = 1; n <= MAX_SIZE; n++)
			t[n] = RECIP_W'(udiv64((64'd1 << RECIP_SH) + 64'(n) - 64'd1, 64'(n)));
		return t;
	endfunction

	function automatic scale_tbl_t build_hquo();
		scale_tbl_t t;
		t[0] = '0;
		for (int n = 1; n <= MAX_SIZE; n++) t[n] = SCALE_W'(udiv64(HALF_PI_Q30, 64'(n)));
		return t;
	endfunction

	function automatic hrem_tbl_t build_hrem();
		hrem_tbl_t t;
		t[0] = '0;
		for (int n = 1; n <= MAX_SIZE; n++)
			t[n] = IDX_W'(HALF_PI_Q30 - udiv64(HALF_PI_Q30, 64'(n)) * 64'(n));
		return t;
	endfunction

	localparam scale_tbl_t SCALE_TBL = build_scale();
	localparam row0_tbl_t  ROW0_TBL  = build_row0();
	localparam recip_tbl_t RECIP_TBL = build_recip();
	localparam scale_tbl_t HQUO_TBL  = build_hquo();
	localparam hrem_tbl_t  HREM_TBL  = build_hrem();

endpackage

[rtl/dctg_if.sv]
// Valid/ready channel interfaces for index requests and coefficient results.
interface dctg_in_if import dctg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;
	modport source(output valid, row_index, col_index, input ready);
	modport sink(input valid, row_index, col_index, output ready);
endinterface

interface dctg_out_if import dctg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [COEF_W-1:0] coefficient;
	logic                     index_error;
	modport source(output valid, coefficient, index_error, input ready);
	modport sink(input valid, coefficient, index_error, output ready);
endinterface

[rtl/dctg_front.sv]
// Index check, phase reduction modulo 4N and quadrant angle, five stages.
module dctg_front import dctg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [IDX_W-1:0]   row_index,
	input  logic [IDX_W-1:0]   col_index,
	input  logic [SIZE_W-1:0]  n,
	output meta_t              meta,
	output logic [ANG_W-1:0]   theta
);
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic [PROD_W-1:0]  p_s1, p_s2, q_s2;
	logic [SIZE_W-1:0]  n_s1, n_s2, n_s3, n_s4;
	logic [IDX_W-1:0]   r_s3, d_s5;
	logic [11:0]        m_s4;
	logic [SCALE_W-1:0] rq_s4, rq_s5;
	meta_t              meta_in;
	meta_t              meta_quad;
	logic [PROD_W-1:0]  p_in;
	logic [39:0]        quo_full;
	logic [PROD_W-1:0]  qn;
	logic [38:0]        d_full;

	always_comb begin
		meta_in.valid    = in_valid;
		meta_in.err      = ({1'b0, row_index} >= n) || ({1'b0, col_index} >= n);
		meta_in.row0     = (row_index == '0);
		meta_in.quad     = '0;
		meta_in.scale    = SCALE_TBL[n];
		meta_in.row0_val = ROW0_TBL[n];
		meta_quad        = meta_s2;
		meta_quad.quad   = q_s2[1:0];
		p_in     = PROD_W'({col_index, 1'b1}) * PROD_W'(row_index);
		quo_full = 40'(p_s1) * 40'(RECIP_TBL[n_s1]);
		qn       = PROD_W'(q_s2 * n_s2);
		d_full   = 39'(m_s4) * 39'(RECIP_TBL[n_s4]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
		end else if (en) begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_quad;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= p_in;
			n_s1  <= n;
			p_s2  <= p_s1;
			q_s2  <= quo_full[RECIP_SH +: PROD_W];
			n_s2  <= n_s1;
			r_s3  <= IDX_W'(p_s2 - qn);
			n_s3  <= n_s2;
			m_s4  <= 12'(r_s3 * HREM_TBL[n_s3]);
			rq_s4 <= SCALE_W'(r_s3 * HQUO_TBL[n_s3]);
			n_s4  <= n_s3;
			d_s5  <= d_full[RECIP_SH +: IDX_W];
			rq_s5 <= rq_s4;
		end
	end

	assign meta  = meta_s5;
	assign theta = ANG_W'(rq_s5) + ANG_W'(d_s5);
endmodule

[rtl/dctg_cell.sv]
// One CORDIC rotation cell: rotates toward zero residual angle and passes on.
module dctg_cell import dctg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [STG_W-1:0]        stage,
	input  meta_t                   meta_i,
	input  logic signed [ANG_W-1:0] x_i,
	input  logic signed [ANG_W-1:0] y_i,
	input  logic signed [ANG_W-1:0] z_i,
	output meta_t                   meta_o,
	output logic signed [ANG_W-1:0] x_o,
	output logic signed [ANG_W-1:0] y_o,
	output logic signed [ANG_W-1:0] z_o
);
	meta_t meta_q;
	logic signed [ANG_W-1:0] x_q, y_q, z_q, dx, dy, at;

	always_comb begin
		dx = y_i >>> stage;
		dy = x_i >>> stage;
		at = signed'(ANG_W'(ATAN_TBL[stage]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_q <= '0;
		end else if (en) begin
			meta_q <= meta_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_i[ANG_W-1]) begin
				x_q <= x_i - dx;
				y_q <= y_i + dy;
				z_q <= z_i - at;
			end else begin
				x_q <= x_i + dx;
				y_q <= y_i - dy;
				z_q <= z_i + at;
			end
		end
	end

	assign meta_o = meta_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign z_o    = z_q;
endmodule

[rtl/dctg_back.sv]
// Quadrant fold, row scaling, rounding and saturation into the output register.
module dctg_back import dctg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  meta_t                    meta_i,
	input  logic signed [ANG_W-1:0]  x_i,
	input  logic signed [ANG_W-1:0]  y_i,
	output logic                     valid,
	output logic signed [COEF_W-1:0] coefficient,
	output logic                     index_error
);
	meta_t meta_s1, meta_s2;
	logic signed [ANG_W-1:0]   c_s1, c_sel;
	logic signed [65:0]        prod_s2;
	logic signed [65:0]        rnd;
	logic signed [21:0]        coef_w;
	logic signed [COEF_W-1:0]  coef_sat;
	logic                      valid_q, err_q;
	logic signed [COEF_W-1:0]  coef_q;

	always_comb begin
		case (meta_i.quad)
			2'd0:    c_sel = x_i;
			2'd1:    c_sel = -y_i;
			2'd2:    c_sel = -x_i;
			default: c_sel = y_i;
		endcase
		rnd    = prod_s2 + (66'sd1 <<< 43);
		coef_w = 22'(rnd >>> 44);
		if (coef_w > 22'sd65536)       coef_sat = 18'sd65536;
		else if (coef_w < -22'sd65536) coef_sat = -18'sd65536;
		else                           coef_sat = COEF_W'(coef_w);
		if (meta_s2.err)       coef_sat = '0;
		else if (meta_s2.row0) coef_sat = signed'(COEF_W'(meta_s2.row0_val));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			valid_q <= 1'b0;
		end else if (en) begin
			meta_s1 <= meta_i;
			meta_s2 <= meta_s1;
			valid_q <= meta_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= c_sel;
			prod_s2 <= 66'(signed'({1'b0, meta_s1.scale})) * 66'(c_s1);
			coef_q  <= coef_sat;
			err_q   <= meta_s2.err;
		end
	end

	assign valid       = valid_q;
	assign coefficient = coef_q;
	assign index_error = err_q;
endmodule

[rtl/dct_coefficient_generator.sv]
// Top level: orthonormal DCT-II matrix entry generator with APB size register.
//
// in_ch carries (row_index, col_index); out_ch returns (coefficient, index_error),
// coefficient being the matrix entry times 65536 in two's complement.
// One result per request, in request order.
// Throughput: one transfer per cycle on each channel while out_ch.ready is high.
// The pipeline has 5 phase stages, one cell per CORDIC rotation and
// 3 scaling/output stages.
// The whole pipeline advances as one; the output register holds a finished
// result while the receiver stalls, and in_ch.ready drops only then.
// matrix_size (APB byte address 0) resets to 8; values above 64 act as 64,
// zero flags every index. Write it only while the pipeline is empty.
// Reset clears all valid bits; no result is pending after reset.
module dct_coefficient_generator import dctg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	dctg_in_if.sink           in_ch,
	dctg_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	logic [SIZE_W-1:0] size_q, n;
	logic en;
	meta_t meta_c [0:CORDIC_STAGES];
	logic signed [ANG_W-1:0] x_c [0:CORDIC_STAGES];
	logic signed [ANG_W-1:0] y_c [0:CORDIC_STAGES];
	logic signed [ANG_W-1:0] z_c [0:CORDIC_STAGES];
	logic [ANG_W-1:0] theta;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? 32'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_MATRIX_SIZE) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign n  = (size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_q;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	dctg_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_ch.valid), .row_index(in_ch.row_index), .col_index(in_ch.col_index),
		.n(n), .meta(meta_c[0]), .theta(theta)
	);

	assign x_c[0] = signed'(ANG_W'(GAIN_Q30));
	assign y_c[0] = '0;
	assign z_c[0] = signed'(theta);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		dctg_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .stage(STG_W'(i)),
			.meta_i(meta_c[i]), .x_i(x_c[i]), .y_i(y_c[i]), .z_i(z_c[i]),
			.meta_o(meta_c[i+1]), .x_o(x_c[i+1]), .y_o(y_c[i+1]), .z_o(z_c[i+1])
		);
	end

	dctg_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.meta_i(meta_c[CORDIC_STAGES]), .x_i(x_c[CORDIC_STAGES]), .y_i(y_c[CORDIC_STAGES]),
		.valid(out_ch.valid), .coefficient(out_ch.coefficient),
		.index_error(out_ch.index_error)
	);
endmodule

[rtl/dctg_checker.sv]
// Port-level checks for the DCT coefficient generator, bound to the top level.
module dctg_checker import dctg_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [COEF_W-1:0] coefficient,
	input logic                     index_error
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(index_error))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> coefficient == '0)
		else $error("index error with nonzero coefficient");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> coefficient <= 18'sd65536 && coefficient >= -18'sd65536)
		else $error("coefficient out of range");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");
endmodule

bind dct_coefficient_generator dctg_checker u_dctg_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.coefficient(out_ch.coefficient), .index_error(out_ch.index_error)
);

[dv/dct_coefficient_generator_test.sv]
// Testbench for the DCT coefficient generator: predicted entries checked against the pipeline.
module dct_coefficient_generator_test;
	import dctg_pkg::*;

	localparam int LATENCY = CORDIC_STAGES + 8;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint HALF_PI = 64'd1686629713;

	typedef struct {
		logic signed [COEF_W-1:0] coefficient;
		logic                     index_error;
	} entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	dctg_in_if in_ch ();
	dctg_out_if out_ch ();

	dct_coefficient_generator dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	entry_t expected_entries[$];
	logic [SIZE_W-1:0] size_reg = SIZE_RESET;
	int errors = 0;
	int sent = 0;
	int received = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.row_index = '0;
		in_ch.col_index = '0;
		out_ch.ready = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("dct_coefficient_generator: mismatch");
			$finish;
		end
	end

	function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
		longint unsigned v, r, b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned inv_gain();
		longint unsigned k;
		k = 64'd1 << 30;
		for (int i = 0; i < CORDIC_STAGES && i <= 30; i++)
			k = (k << 30) / sqrt_floor((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
		return k;
	endfunction

	function automatic longint quadrant_cos(input int q, input longint theta);
		longint x, y, z, dx, dy;
		x = longint'(inv_gain());
		y = 0;
		z = theta;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TBL[i & 31]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TBL[i & 31]);
			end
		end
		case (q)
			0: return x;
			1: return -y;
			2: return -x;
			default: return y;
		endcase
	endfunction

	function automatic entry_t dct_entry(input logic [IDX_W-1:0] k, input logic [IDX_W-1:0] j);
		entry_t e;
		longint unsigned n, p, r;
		longint coef, theta, s;
		n = (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
		e.coefficient = '0;
		e.index_error = 1'b1;
		if (k >= n || j >= n) return e;
		if (k == 0) begin
			coef = longint'((sqrt_floor((64'd1 << 34) / n) + 1) >> 1);
		end else begin
			p = ((2 * longint'(j) + 1) * k) % (4 * n);
			r = p % n;
			theta = longint'((HALF_PI * r) / n);
			s = longint'(sqrt_floor((64'd1 << 61) / n));
			// s fits 31 bits and cos 31 bits, product fits in 63
			coef = (s * quadrant_cos(int'(p / n), theta) + (64'sd1 <<< 43)) >>> 44;
		end
		if (coef > 65536) coef = 65536;
		if (coef < -65536) coef = -65536;
		e.coefficient = COEF_W'(coef);
		e.index_error = 1'b0;
		return e;
	endfunction

	// receiver: stall at random, check every transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				received++;
				if (expected_entries.size() == 0) begin
					$error("result with nothing expected: coefficient %0d", out_ch.coefficient);
					errors++;
				end else begin
					entry_t e;
					e = expected_entries.pop_front();
					if (out_ch.coefficient !== e.coefficient) begin
						$error("coefficient: expected %0d, got %0d", e.coefficient,
							out_ch.coefficient);
						errors++;
					end
					if (out_ch.index_error !== e.index_error) begin
						$error("index_error: expected %0b, got %0b", e.index_error,
							out_ch.index_error);
						errors++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// valid stays up between back-to-back items; drain() drops it
	task automatic send_entry(input logic [IDX_W-1:0] k, input logic [IDX_W-1:0] j);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.row_index <= k;
		in_ch.col_index <= j;
		expected_entries.push_back(dct_entry(k, j));
		sent++;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] v);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= APB_AW'(REG_MATRIX_SIZE) << 2;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		size_reg = v;
	endtask

	task automatic set_pressure(input int idle, input int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
	endtask

	task automatic test_reset_size();
		// default size 8: edge of valid range and just past it
		send_entry(0, 0);
		send_entry(7, 7);
		send_entry(8, 0);
		send_entry(0, 8);
		send_entry(63, 63);
	endtask

	task automatic test_directed();
		write_size(7'd64);
		send_entry(0, 0);
		send_entry(1, 0);
		send_entry(63, 63);
		send_entry(32, 0);
		send_entry(63, 0);
		send_entry(1, 63);
		send_entry(6'b101010, 6'b010101);
		write_size(7'd1);
		send_entry(0, 0);
		send_entry(0, 1);
		write_size(7'd0);
		send_entry(0, 0);
		write_size(7'd127);
		send_entry(63, 62);
		write_size(7'd65);
		send_entry(0, 63);
		write_size(7'd2);
		send_entry(1, 0);
		send_entry(1, 1);
		write_size(7'd3);
		send_entry(2, 2);
	endtask

	task automatic test_random(input int count);
		logic [SIZE_W-1:0] n;
		int lim;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				case ($urandom_range(4))
					0: n = 7'd64;
					1: n = 7'd1;
					2: n = SIZE_W'($urandom_range(127));
					default: n = SIZE_W'($urandom_range(64, 1));
				endcase
				write_size(n);
			end
			lim = (size_reg == 0) ? 63 : ((size_reg > MAX_SIZE) ? 63 : size_reg - 1);
			// mostly in-range indices, some anywhere
			if ($urandom_range(9) < 8)
				send_entry(IDX_W'($urandom_range(lim)), IDX_W'($urandom_range(lim)));
			else
				send_entry(IDX_W'($urandom), IDX_W'($urandom));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_directed();
		set_pressure(0, 0);
		test_random(130);
		set_pressure(73, 0);
		test_random(120);
		drain(); // sender holds off until every result is back
		set_pressure(0, 73);
		test_random(120);
		set_pressure(15, 15);
		test_random(130);
		set_pressure(0, 0);
		drain();
		$display("sent %0d index pairs over sizes 0..127 and four idle/stall mixes,", sent);
		$display("received %0d coefficients", received);
		if (errors == 0 && expected_entries.size() == 0)
			$display("dct_coefficient_generator: match");
		else
			$display("dct_coefficient_generator: mismatch");
		$finish;
	end
endmodule

[filelist.f]
rtl/dctg_pkg.sv
rtl/dctg_if.sv
rtl/dctg_front.sv
rtl/dctg_cell.sv
rtl/dctg_back.sv
rtl/dct_coefficient_generator.sv
rtl/dctg_checker.sv
dv/dct_coefficient_generator_test.sv
